@@ hw/rtl/msc_pkg.sv @@
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants for the array-backed multiset block.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int CAPACITY_ENTRIES = 32;
  localparam int DATA_W           = 32;
  localparam int KIND_W           = 2;
  localparam int CNT_W            = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT    = 2'd0,
    KIND_COUNT     = 2'd1,
    KIND_ERASE_ONE = 2'd2,
    KIND_ERASE_ALL = 2'd3
  } kind_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic             push;
    logic [CNT_W-1:0] match_count;
    logic             found;
    logic             rejected;
    logic [CNT_W-1:0] occupancy;
  } res_t;

endpackage

@@ hw/rtl/msc_if.sv @@
// ----------------------------------------------------------------------------
// msc_if
// Valid/ready channels for requests and responses of the multiset block.
// ----------------------------------------------------------------------------
interface msc_req_if;
  logic                             valid;
  logic                             ready;
  logic [msc_pkg::KIND_W-1:0]       kind;
  logic signed [msc_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface msc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [msc_pkg::CNT_W-1:0]   match_count;
  logic                        found;
  logic                        rejected;
  logic [msc_pkg::CNT_W-1:0]   occupancy;

  modport source (output valid, output match_count, output found, output rejected,
                  output occupancy, input ready);
  modport sink (input valid, input match_count, input found, input rejected,
                input occupancy, output ready);
endinterface

@@ hw/rtl/msc_ram.sv @@
// ----------------------------------------------------------------------------
// msc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/msc_ctrl.sv @@
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer: scans the entry memory, counts matches, compacts or shifts.
// ----------------------------------------------------------------------------
module msc_ctrl #(
  parameter int CAPACITY_ENTRIES = msc_pkg::CAPACITY_ENTRIES,
  localparam int AW = (CAPACITY_ENTRIES > 1) ? $clog2(CAPACITY_ENTRIES) : 1,
  localparam int CW = $clog2(CAPACITY_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  msc_req_if.sink                     req,
  input  logic                        out_free,
  output msc_pkg::res_t               res,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [msc_pkg::DATA_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [msc_pkg::DATA_W-1:0]  mem_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                     state, state_next;
  msc_pkg::kind_t             kind, kind_next;
  logic [msc_pkg::DATA_W-1:0] value, value_next;
  logic [CW-1:0]              fill, fill_next;
  logic [CW-1:0]              idx, idx_next;
  logic                       rd_valid, rd_valid_next;
  logic [CW-1:0]              rd_pos, rd_pos_next;
  logic [CW-1:0]              wr, wr_next;
  logic [CW-1:0]              hits, hits_next;
  logic [CW-1:0]              last_pos, last_pos_next;
  logic                       hit, hit_next;
  logic                       found, found_next;
  logic                       rejected, rejected_next;

  logic                       accept;
  logic                       match;
  logic                       more;
  logic [CW-1:0]              back_pos;
  logic [CW+msc_pkg::CNT_W-1:0] hits_ext;
  logic [CW+msc_pkg::CNT_W-1:0] fill_ext;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign match     = rd_valid && (mem_rdata == value);
  assign more      = (idx < fill);
  assign back_pos  = rd_pos - CW'(1);
  assign hits_ext  = {{msc_pkg::CNT_W{1'b0}}, hits};
  assign fill_ext  = {{msc_pkg::CNT_W{1'b0}}, fill};

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    value_next    = value;
    fill_next     = fill;
    idx_next      = idx;
    rd_valid_next = 1'b0;
    rd_pos_next   = rd_pos;
    wr_next       = wr;
    hits_next     = hits;
    last_pos_next = last_pos;
    hit_next      = hit;
    found_next    = found;
    rejected_next = rejected;
    mem_we        = 1'b0;
    mem_waddr     = wr[AW-1:0];
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = idx[AW-1:0];
    res.push        = 1'b0;
    res.match_count = hits_ext[msc_pkg::CNT_W-1:0];
    res.found       = found;
    res.rejected    = rejected;
    res.occupancy   = fill_ext[msc_pkg::CNT_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          kind_next     = msc_pkg::kind_t'(req.kind);
          value_next    = req.value;
          idx_next      = '0;
          wr_next       = '0;
          hits_next     = '0;
          hit_next      = 1'b0;
          found_next    = 1'b0;
          rejected_next = 1'b0;
          if (msc_pkg::kind_t'(req.kind) == msc_pkg::KIND_INSERT) begin
            if (fill == CW'(CAPACITY_ENTRIES)) begin
              rejected_next = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = fill[AW-1:0];
              mem_wdata = req.value;
              fill_next = fill + CW'(1);
            end
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // read one entry per cycle; its data comes back in the next cycle
        if (more) begin
          mem_re        = 1'b1;
          idx_next      = idx + CW'(1);
          rd_valid_next = 1'b1;
          rd_pos_next   = idx;
        end
        if (match) begin
          if (kind == msc_pkg::KIND_ERASE_ONE) begin
            last_pos_next = rd_pos;
            hit_next      = 1'b1;
          end else begin
            hits_next = hits + CW'(1);
          end
        end
        // compaction writes land at or below the entry just read
        if (kind == msc_pkg::KIND_ERASE_ALL && rd_valid && !match) begin
          mem_we  = 1'b1;
          wr_next = wr + CW'(1);
        end
        if (!more && !rd_valid) begin
          unique case (kind)
            msc_pkg::KIND_ERASE_ONE: begin
              if (hit) begin
                idx_next   = last_pos + CW'(1);
                state_next = ST_SHIFT;
              end else begin
                state_next = ST_FINISH;
              end
            end
            msc_pkg::KIND_ERASE_ALL: begin
              fill_next  = wr;
              state_next = ST_FINISH;
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        if (more) begin
          mem_re        = 1'b1;
          idx_next      = idx + CW'(1);
          rd_valid_next = 1'b1;
          rd_pos_next   = idx;
        end
        if (rd_valid) begin
          mem_we    = 1'b1;
          mem_waddr = back_pos[AW-1:0];
        end
        if (!more && !rd_valid) begin
          fill_next  = fill - CW'(1);
          found_next = 1'b1;
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          res.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      rd_valid <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind     <= kind_next;
    value    <= value_next;
    idx      <= idx_next;
    rd_pos   <= rd_pos_next;
    wr       <= wr_next;
    hits     <= hits_next;
    last_pos <= last_pos_next;
    hit      <= hit_next;
    found    <= found_next;
    rejected <= rejected_next;
  end

endmodule

@@ hw/rtl/multiset_count_insert_erase.sv @@
// ----------------------------------------------------------------------------
// multiset_count_insert_erase
// Multiset of signed 32-bit values held in insertion order in a single entry RAM.
// ----------------------------------------------------------------------------
// throughput: one request at a time, set by the single-read-port RAM scan
//   at one entry per cycle (erase one scans, then shifts the tail)
// a finished response waits in the output register while the next request
//   is taken; synchronous reset empties the store, the RAM is not cleared
module multiset_count_insert_erase #(
  parameter int CAPACITY_ENTRIES = msc_pkg::CAPACITY_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  msc_req_if.sink   req,
  msc_rsp_if.source rsp
);

  localparam int AW = (CAPACITY_ENTRIES > 1) ? $clog2(CAPACITY_ENTRIES) : 1;

  msc_pkg::res_t              res;
  logic                       out_free;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [msc_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [msc_pkg::DATA_W-1:0] mem_rdata;

  assign out_free = !rsp.valid || rsp.ready;

  msc_ctrl #(
    .CAPACITY_ENTRIES(CAPACITY_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_free  (out_free),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  msc_ram #(
    .WIDTH(msc_pkg::DATA_W),
    .DEPTH(CAPACITY_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res.push) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      rsp.match_count <= res.match_count;
      rsp.found       <= res.found;
      rsp.rejected    <= res.rejected;
      rsp.occupancy   <= res.occupancy;
    end
  end

endmodule

@@ hw/rtl/msc_checker.sv @@
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks for the multiset block, bound to the top level.
// ----------------------------------------------------------------------------
module msc_checker #(
  parameter int CAPACITY_ENTRIES = msc_pkg::CAPACITY_ENTRIES
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [msc_pkg::CNT_W-1:0]  match_count,
  input logic                       found,
  input logic                       rejected,
  input logic [msc_pkg::CNT_W-1:0]  occupancy
);

  logic       req_acc;
  logic       rsp_acc;
  logic [1:0] pending;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // requests taken whose response has not been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_acc && !rsp_acc) begin
      pending <= pending + 2'd1;
    end else if (rsp_acc && !req_acc) begin
      pending <= pending - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(occupancy) && $stable(match_count))
    else $error("response changed while stalled");

  a_no_extra_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_acc |-> pending != 2'd0)
    else $error("response transaction without a pending request");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !req_ready)
    else $error("request taken while two responses are owed");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rejected |-> !found && occupancy == msc_pkg::CNT_W'(CAPACITY_ENTRIES))
    else $error("insert refused while the store was not full");

endmodule

bind multiset_count_insert_erase msc_checker #(
  .CAPACITY_ENTRIES(CAPACITY_ENTRIES)
) u_msc_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .match_count (rsp.match_count),
  .found       (rsp.found),
  .rejected    (rsp.rejected),
  .occupancy   (rsp.occupancy)
);

@@ bench/multiset_count_insert_erase_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiset_count_insert_erase_checker
// Watches the request and response channels of the multiset block, keeps its
// own copy of the held entries, predicts the response of every accepted
// request and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module multiset_count_insert_erase_checker (
  input  logic      clk,
  input  logic      rst,
  msc_req_if        req,
  msc_rsp_if        rsp,
  output int        mismatches,
  output int        outstanding
);

  typedef struct packed {
    logic [msc_pkg::CNT_W-1:0] match_count;
    logic                      found;
    logic                      rejected;
    logic [msc_pkg::CNT_W-1:0] occupancy;
  } reply_t;

  logic [msc_pkg::DATA_W-1:0] held [msc_pkg::CAPACITY_ENTRIES];
  int                         held_count;
  reply_t                     expected_replies [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    held_count  = 0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch, %s: got %0d, expected %0d", $time, what, got, want);
    mismatches = mismatches + 1;
  endtask

  // updates the held entries and returns the response the block should give
  function automatic reply_t apply_request(msc_pkg::kind_t k,
                                           logic [msc_pkg::DATA_W-1:0] v);
    reply_t r;
    int     pos;
    int     wr;
    r = '0;
    case (k)
      msc_pkg::KIND_INSERT: begin
        if (held_count >= msc_pkg::CAPACITY_ENTRIES) begin
          r.rejected = 1'b1;
        end else begin
          held[held_count] = v;
          held_count++;
        end
      end
      msc_pkg::KIND_COUNT: begin
        for (int i = 0; i < held_count; i++)
          if (held[i] == v) r.match_count++;
      end
      msc_pkg::KIND_ERASE_ONE: begin
        // last match goes, the tail moves down one place
        pos = -1;
        for (int i = 0; i < held_count; i++)
          if (held[i] == v) pos = i;
        if (pos >= 0) begin
          for (int i = pos; i < held_count - 1; i++)
            held[i] = held[i + 1];
          held_count--;
          r.found = 1'b1;
        end
      end
      default: begin
        wr = 0;
        for (int rd = 0; rd < held_count; rd++) begin
          if (held[rd] == v) begin
            r.match_count++;
          end else begin
            held[wr] = held[rd];
            wr++;
          end
        end
        held_count = wr;
      end
    endcase
    r.occupancy = msc_pkg::CNT_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      held_count = 0;
      expected_replies.delete();
      outstanding <= 0;
    end else begin
      // a response always belongs to a request accepted at an earlier edge
      if (rsp.valid && rsp.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("responses with none pending", 1, 0);
        end else begin
          want = expected_replies.pop_front();
          if (rsp.match_count !== want.match_count)
            report_mismatch("match_count", rsp.match_count, want.match_count);
          if (rsp.found !== want.found)
            report_mismatch("found", rsp.found, want.found);
          if (rsp.rejected !== want.rejected)
            report_mismatch("rejected", rsp.rejected, want.rejected);
          if (rsp.occupancy !== want.occupancy)
            report_mismatch("occupancy", rsp.occupancy, want.occupancy);
        end
      end
      if (req.valid && req.ready)
        expected_replies.push_back(apply_request(msc_pkg::kind_t'(req.kind), req.value));
      outstanding <= expected_replies.size();
    end
  end

endmodule

@@ bench/multiset_count_insert_erase_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiset_count_insert_erase_tb
// Drives requests into the multiset block with random gaps and response
// stalls: a directed opening on the extremes and corner cases, then random
// phases that fill, drain or mix the store over a small pool of values.
// ----------------------------------------------------------------------------
module multiset_count_insert_erase_tb;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 2 * msc_pkg::CAPACITY_ENTRIES + 40;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   cycle_count;
  bit   calm;

  msc_req_if req_ch ();
  msc_rsp_if rsp_ch ();

  multiset_count_insert_erase dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  multiset_count_insert_erase_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multiset_count_insert_erase_tb: FAIL");
      $finish;
    end
  end

  function automatic int idle_draw();
    if (calm) return 0;
    return $urandom_range(0, 8);
  endfunction

  // valid stays high after a transaction unless the next one waits
  task automatic send_request(msc_pkg::kind_t k, logic [msc_pkg::DATA_W-1:0] v);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= k;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic msc_pkg::kind_t pick_kind(mix_t mix);
    int r;
    int ins;
    int cnt;
    int one;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin ins = 75; cnt = 85; one = 95; end
      MIX_DRAIN: begin ins = 20; cnt = 35; one = 80; end
      default:   begin ins = 45; cnt = 65; one = 85; end
    endcase
    if (r < ins) return msc_pkg::KIND_INSERT;
    if (r < cnt) return msc_pkg::KIND_COUNT;
    if (r < one) return msc_pkg::KIND_ERASE_ONE;
    return msc_pkg::KIND_ERASE_ALL;
  endfunction

  function automatic logic [msc_pkg::DATA_W-1:0] pool_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return msc_pkg::DATA_W'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // response side: random stall before each transaction
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin
    logic [msc_pkg::DATA_W-1:0] pool [4];
    mix_t                       mix;
    int                         sent;
    int                         phase_len;
    int                         phase;
    rst          = 1'b1;
    calm         = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.kind  = msc_pkg::KIND_INSERT;
    req_ch.value = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store: nothing to count or remove
    send_request(msc_pkg::KIND_COUNT,     32'h0000_0000);
    send_request(msc_pkg::KIND_ERASE_ONE, 32'h0000_0000);
    send_request(msc_pkg::KIND_ERASE_ALL, 32'hffff_ffff);
    send_request(msc_pkg::KIND_INSERT,    32'h8000_0000);
    send_request(msc_pkg::KIND_INSERT,    32'h7fff_ffff);
    send_request(msc_pkg::KIND_INSERT,    32'h0000_0000);
    send_request(msc_pkg::KIND_INSERT,    32'hffff_ffff);
    send_request(msc_pkg::KIND_INSERT,    32'h8000_0000);
    send_request(msc_pkg::KIND_INSERT,    32'h7fff_ffff);
    send_request(msc_pkg::KIND_COUNT,     32'h8000_0000);
    send_request(msc_pkg::KIND_COUNT,     32'h7fff_ffff);
    send_request(msc_pkg::KIND_COUNT,     32'h1234_5678);
    send_request(msc_pkg::KIND_ERASE_ONE, 32'h8000_0000);
    send_request(msc_pkg::KIND_ERASE_ONE, 32'h5555_aaaa);
    send_request(msc_pkg::KIND_COUNT,     32'h8000_0000);
    send_request(msc_pkg::KIND_ERASE_ALL, 32'h7fff_ffff);
    send_request(msc_pkg::KIND_ERASE_ALL, 32'haaaa_5555);
    send_request(msc_pkg::KIND_ERASE_ONE, 32'hffff_ffff);
    send_request(msc_pkg::KIND_ERASE_ALL, 32'h8000_0000);
    send_request(msc_pkg::KIND_ERASE_ALL, 32'h0000_0000);
    wait_drained();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mix       = mix_t'($urandom_range(0, 2));
      phase_len = $urandom_range(30, 90);
      calm      = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 4; i++) pool[i] = pool_value();
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 99) < 85)
          send_request(pick_kind(mix), pool[$urandom_range(0, 3)]);
        else
          send_request(pick_kind(mix), $urandom());
        sent++;
      end
      if (phase == 0 || $urandom_range(0, 2) == 0) wait_drained();
      phase++;
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("multiset_count_insert_erase_tb: PASS");
    end else begin
      $display("multiset_count_insert_erase_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/msc_pkg.sv
hw/rtl/msc_if.sv
hw/rtl/msc_ram.sv
hw/rtl/msc_ctrl.sv
hw/rtl/multiset_count_insert_erase.sv
hw/rtl/msc_checker.sv
bench/multiset_count_insert_erase_checker.sv
bench/multiset_count_insert_erase_tb.sv
